FILE: hdl/pprs_pkg.sv
// Shared types, constants and codes for the polar parameter ramp smoother.
package pprs_pkg;
  localparam int NumSources = 16;
  localparam int SlotW = 5;
  localparam int SrcW = 4;
  localparam logic [15:0] RampReset = 16'd4410;

  localparam logic [2:0] ReqRampRad = 3'd0;
  localparam logic [2:0] ReqRampAz  = 3'd1;
  localparam logic [2:0] ReqSetRad  = 3'd2;
  localparam logic [2:0] ReqSetAz   = 3'd3;
  localparam logic [2:0] ReqTick    = 3'd4;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [SrcW-1:0]    src_idx;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [SrcW-1:0]    out_source;
    logic signed [31:0] out_radius;
    logic signed [31:0] out_azimuth;
    logic               last;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic             load_req;
    logic             prep;      // read operands of the set slot
    logic             div_start;
    logic             set_write; // write back a ramp or direct set
    logic             tick_upd;  // update one slot pair in a tick
    logic             snap;      // snap this pair to target
    logic             clr_cnt;
    logic             inc_cnt;
    logic [SrcW-1:0]  src;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic cnt_reached;
  } sts_t;

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    if (v > 50'sh0_7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    if (v < -50'sh0_8000_0000_0000) return 48'sh8000_0000_0000;
    return v[47:0];
  endfunction
endpackage

FILE: hdl/pprs_if.sv
// Valid/ready channel interfaces for requests and results.
interface pprs_req_if import pprs_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface pprs_res_if import pprs_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: hdl/pprs_div.sv
// Restoring divider: signed 50-bit dividend by 16-bit divisor, one bit a cycle.
module pprs_div import pprs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [49:0]  dividend,
  input  logic [15:0]         divisor,
  output logic                done,
  output logic signed [49:0]  quotient
);
  logic [49:0] q_r, q_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, neg_r, neg_nxt, done_r, done_nxt;
  logic [16:0] shifted;
  logic [17:0] diff;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; neg_nxt = neg_r; done_nxt = 1'b0;
    shifted = {rem_r[15:0], q_r[49]};
    diff = {1'b0, shifted} - {2'b0, divisor};
    if (start) begin
      neg_nxt = dividend[49];
      q_nxt = dividend[49] ? 50'(-dividend) : dividend;
      rem_nxt = '0;
      cnt_nxt = 6'd50;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[17]) begin
        rem_nxt = diff[16:0];
        q_nxt = {q_r[48:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt = {q_r[48:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign quotient = neg_r ? 50'(-q_r) : q_r;
endmodule

FILE: hdl/pprs_datapath.sv
// Datapath: state memories, azimuth wrap, step divider, tick accumulation.
module pprs_datapath import pprs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  cmd_t               cmd,
  input  req_t               req_in,
  output sts_t               sts,
  output logic signed [31:0] rad_o,
  output logic signed [31:0] az_o
);
  logic [15:0] ramp_r;
  logic [16:0] cnt_r;
  req_t        req_r;
  logic signed [47:0] cur_r [2*NumSources];
  logic signed [31:0] tgt_r [2*NumSources];
  logic signed [47:0] stp_r [2*NumSources];
  logic signed [31:0] rad_r, az_r;
  logic signed [32:0] ntgt_r;   // target as signed Q33.0 integer, may be shifted by a turn
  logic signed [47:0] old_r;
  logic        dstart_r;
  logic [15:0] eff;
  logic [SlotW-1:0] slot;
  logic signed [49:0] qt;
  logic        ddone;

  assign eff = (ramp_r == 16'd0) ? 16'd1 : ramp_r;
  assign slot = {req_r.req_type == ReqRampAz || req_r.req_type == ReqSetAz, req_r.src_idx};

  pprs_div u_div (
    .clk, .rst_n, .start(dstart_r),
    .dividend(50'($signed({ntgt_r, 16'd0})) - 50'(old_r)),
    .divisor(eff), .done(ddone), .quotient(qt)
  );

  // azimuth wrap of the operands
  logic signed [47:0] cur_sel, old_w;
  logic signed [32:0] new_w;
  logic signed [48:0] n32, o32, gap;
  always_comb begin
    cur_sel = cur_r[slot];
    old_w = cur_sel;
    new_w = 33'(req_r.value);
    if (req_r.req_type == ReqRampAz) begin
      old_w = {16'd0, cur_sel[31:0]};
      new_w = {17'd0, req_r.value[15:0]};
    end
    n32 = {new_w, 16'd0};
    o32 = 49'(old_w);
    gap = (o32 > n32) ? o32 - n32 : n32 - o32;
    if (req_r.req_type == ReqRampAz && gap > 49'sh0_8000_0000) begin
      if (n32 > o32) new_w = new_w - 33'sd65536;
      else new_w = new_w + 33'sd65536;
    end
  end

  logic signed [47:0] acc_r, acc_a;
  always_comb begin
    acc_r = sat48(50'(cur_r[{1'b0, cmd.src}]) + 50'(stp_r[{1'b0, cmd.src}]));
    acc_a = sat48(50'(cur_r[{1'b1, cmd.src}]) + 50'(stp_r[{1'b1, cmd.src}]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_r <= RampReset;
      cnt_r <= '0;
      dstart_r <= 1'b0;
      for (int i = 0; i < 2*NumSources; i++) begin
        cur_r[i] <= '0; tgt_r[i] <= '0; stp_r[i] <= '0;
      end
    end else begin
      dstart_r <= cmd.div_start;
      if (cfg_we) ramp_r <= cfg_wdata;
      if (cmd.clr_cnt) cnt_r <= '0;
      else if (cmd.inc_cnt) cnt_r <= cnt_r + 17'd1;
      if (cmd.prep) begin
        old_r <= old_w;
        ntgt_r <= new_w;
        if (req_r.req_type == ReqRampAz) cur_r[slot] <= old_w;
      end
      if (cmd.set_write) begin
        if (req_r.req_type == ReqSetRad || req_r.req_type == ReqSetAz) begin
          cur_r[slot] <= 48'(req_r.value) <<< 16;
          tgt_r[slot] <= req_r.value;
          stp_r[slot] <= '0;
        end else begin
          tgt_r[slot] <= ntgt_r[31:0];
          stp_r[slot] <= sat48(qt);
        end
      end
      if (cmd.tick_upd) begin
        if (cmd.snap) begin
          cur_r[{1'b0, cmd.src}] <= 48'(tgt_r[{1'b0, cmd.src}]) <<< 16;
          cur_r[{1'b1, cmd.src}] <= 48'(tgt_r[{1'b1, cmd.src}]) <<< 16;
          stp_r[{1'b0, cmd.src}] <= '0;
          stp_r[{1'b1, cmd.src}] <= '0;
        end else begin
          cur_r[{1'b0, cmd.src}] <= acc_r;
          cur_r[{1'b1, cmd.src}] <= acc_a;
        end
      end
    end
    if (cmd.load_req) req_r <= req_in;
    if (cmd.tick_upd) begin
      rad_r <= cmd.snap ? tgt_r[{1'b0, cmd.src}] : acc_r[47:16];
      az_r  <= cmd.snap ? tgt_r[{1'b1, cmd.src}] : acc_a[47:16];
    end
  end

  assign sts.div_done = ddone;
  assign sts.cnt_reached = cnt_r >= {1'b0, eff};
  assign rad_o = rad_r;
  assign az_o = az_r;
endmodule

FILE: hdl/pprs_ctrl.sv
// Controller: request decode, divide sequencing and tick sweep.
module pprs_ctrl import pprs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  input  sts_t sts,
  output cmd_t cmd,
  output logic out_valid,
  input  logic out_ready,
  output logic [SrcW-1:0] out_src,
  output logic out_last
);
  localparam logic [2:0] StIdle = 3'd0, StPrep = 3'd1, StDiv = 3'd2,
                         StWait = 3'd3, StUpd = 3'd4, StEmit = 3'd5;
  logic [2:0] st_r, st_nxt;
  logic [SrcW-1:0] src_r, src_nxt;
  logic snap_r, snap_nxt;
  logic [2:0] rt_r, rt_nxt;

  always_comb begin
    st_nxt = st_r; src_nxt = src_r; snap_nxt = snap_r; rt_nxt = rt_r;
    cmd = '0;
    cmd.src = src_r;
    cmd.snap = snap_r;
    in_ready = (st_r == StIdle);
    out_valid = (st_r == StEmit);
    unique case (st_r)
      StIdle: if (in_valid) begin
        cmd.load_req = 1'b1;
        rt_nxt = in_data.req_type;
        if (in_data.req_type == ReqTick) begin
          snap_nxt = sts.cnt_reached;
          if (sts.cnt_reached) cmd.clr_cnt = 1'b1;
          else cmd.inc_cnt = 1'b1;
          src_nxt = '0;
          st_nxt = StUpd;
        end else if (in_data.req_type < ReqTick &&
                     32'(in_data.src_idx) < NumSources) begin
          cmd.clr_cnt = 1'b1;
          st_nxt = StPrep;
        end
      end
      StPrep: begin
        if (rt_r == ReqSetRad || rt_r == ReqSetAz) begin
          cmd.set_write = 1'b1;
          st_nxt = StIdle;
        end else begin
          cmd.prep = 1'b1;
          st_nxt = StDiv;
        end
      end
      StDiv: begin
        cmd.div_start = 1'b1;
        st_nxt = StWait;
      end
      StWait: if (sts.div_done) begin
        cmd.set_write = 1'b1;
        st_nxt = StIdle;
      end
      StUpd: begin
        cmd.tick_upd = 1'b1;
        st_nxt = StEmit;
      end
      StEmit: if (out_ready) begin
        if (32'(src_r) == NumSources - 1) st_nxt = StIdle;
        else begin
          src_nxt = src_r + SrcW'(1);
          st_nxt = StUpd;
        end
      end
      default: st_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StIdle; src_r <= '0;
    end else begin
      st_r <= st_nxt; src_r <= src_nxt;
    end
    snap_r <= snap_nxt; rt_r <= rt_nxt;
  end

  assign out_src = src_r;
  assign out_last = (32'(src_r) == NumSources - 1);

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("accept during emit");
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> st_r == StIdle) else $error("run did not end");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> st_r == StWait) else $error("divide lost");
endmodule

FILE: hdl/polar_parameter_ramp_smoother.sv
// Top level of the polar parameter ramp smoother.
// Channel  Dir  Payload                                   Handshake
// in       in   req_type, src_idx, value                  valid/ready
// out      out  out_source, out_radius, out_azimuth, last  valid/ready
// cfg      in   ramp_length                               write enable
// Ramp set: runs the 50-step bit-serial divider before the next transfer.
// Direct set: written in the prep state. Tick: an update and an emit per source.
// Reset: synchronous, active low; clears control, memories; ramp 4410.
// A stalled result holds the sweep; no input is taken until a run ends.
module polar_parameter_ramp_smoother import pprs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  pprs_req_if.sink    in_ch,
  pprs_res_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  cmd_t cmd;
  sts_t sts;
  logic [SrcW-1:0] src;
  logic last;
  logic signed [31:0] rad, az;

  pprs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_data(in_ch.data), .sts, .cmd, .out_valid(out_ch.valid),
    .out_ready(out_ch.ready), .out_src(src), .out_last(last)
  );

  pprs_datapath u_dp (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .cmd, .req_in(in_ch.data), .sts,
    .rad_o(rad), .az_o(az)
  );

  assign out_ch.data.out_source = src;
  assign out_ch.data.out_radius = rad;
  assign out_ch.data.out_azimuth = az;
  assign out_ch.data.last = last;
endmodule
